// ----- src/vrp_pkg.sv -----
// vrp_pkg: shared types, constants and tables for the vertex rotate/project pipeline
// no dependencies
`timescale 1ns / 1ps
package vrp_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int ANGLE_BITS_DEF = 16;

	localparam int CW        = 34;
	localparam int STEPS     = 16;
	localparam int TRIG_W    = 16;
	localparam int PIXEL_W   = 16;
	localparam int CENTER_W  = 10;
	localparam int FOCAL_W   = 16;
	localparam int VDIST_W   = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int MIN_DEPTH = 26;

	localparam logic signed [CW-1:0] CORDIC_GAIN  = CW'(64'sh26DD3B6A);
	localparam logic signed [CW-1:0] TURN_QUARTER = CW'(64'sh40000000);
	localparam logic signed [CW-1:0] TURN_HALF    = CW'(64'sh80000000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_FOCAL,
		REG_VDIST
	} cfg_reg_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic                 flip;
	} cord_t;

	function automatic logic signed [CW-1:0] atan_turn(input int i);
		case (i)
			0:  return CW'(32'sh20000000);
			1:  return CW'(32'sh12E4051E);
			2:  return CW'(32'sh09FB385B);
			3:  return CW'(32'sh051111D4);
			4:  return CW'(32'sh028B0D43);
			5:  return CW'(32'sh0145D7E1);
			6:  return CW'(32'sh00A2F61E);
			7:  return CW'(32'sh00517C55);
			8:  return CW'(32'sh0028BE53);
			9:  return CW'(32'sh00145F2F);
			10: return CW'(32'sh000A2F98);
			11: return CW'(32'sh000517CC);
			12: return CW'(32'sh00028BE6);
			13: return CW'(32'sh000145F3);
			14: return CW'(32'sh0000A2FA);
			15: return CW'(32'sh0000517D);
			default: return '0;
		endcase
	endfunction

endpackage

// ----- src/vrp_cordic_cell.sv -----
// vrp_cordic_cell: one registered cordic micro-rotation for the three angle lanes
// depends on vrp_pkg
`timescale 1ns / 1ps
module vrp_cordic_cell
	import vrp_pkg::*;
#(
	parameter int STEP = 0,
	parameter int SW   = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  cord_t [2:0]   lane_in,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output cord_t [2:0]   lane_out,
	output logic [SW-1:0] side_out
);

	cord_t [2:0]   lane_d;
	cord_t [2:0]   lane_q;
	logic [SW-1:0] side_q;
	logic          valid_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lane_d[k] = lane_in[k];
			if (!lane_in[k].z[CW-1]) begin
				lane_d[k].x = lane_in[k].x - (lane_in[k].y >>> STEP);
				lane_d[k].y = lane_in[k].y + (lane_in[k].x >>> STEP);
				lane_d[k].z = lane_in[k].z - atan_turn(STEP);
			end else begin
				lane_d[k].x = lane_in[k].x + (lane_in[k].y >>> STEP);
				lane_d[k].y = lane_in[k].y - (lane_in[k].x >>> STEP);
				lane_d[k].z = lane_in[k].z + atan_turn(STEP);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q <= lane_d;
			side_q <= side_in;
		end
	end

	assign out_valid = valid_q;
	assign lane_out  = lane_q;
	assign side_out  = side_q;

endmodule

// ----- src/vrp_rot.sv -----
// vrp_rot: two-stage planar rotation of a coordinate pair by a q1.14 sine/cosine
// depends on vrp_pkg
`timescale 1ns / 1ps
module vrp_rot
	import vrp_pkg::*;
#(
	parameter int RW = 18,
	parameter int SW = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic signed [RW-1:0]     a,
	input  logic signed [RW-1:0]     b,
	input  logic signed [TRIG_W-1:0] c,
	input  logic signed [TRIG_W-1:0] s,
	input  logic [SW-1:0]            side_in,
	output logic                     out_valid,
	output logic signed [RW-1:0]     na,
	output logic signed [RW-1:0]     nb,
	output logic [SW-1:0]            side_out
);

	localparam int PW   = RW + TRIG_W;
	localparam int SUMW = PW + 1;

	logic signed [PW-1:0]   ac_s1, bs_s1, as_s1, bc_s1;
	logic [SW-1:0]          side_s1, side_s2;
	logic                   valid_s1, valid_s2;
	logic signed [SUMW-1:0] dif, sum, rnd_a, rnd_b;
	logic signed [RW-1:0]   na_s2, nb_s2;

	always_comb begin
		dif   = SUMW'(ac_s1) - SUMW'(bs_s1);
		sum   = SUMW'(as_s1) + SUMW'(bc_s1);
		rnd_a = (dif + SUMW'(1 << 13)) >>> 14;
		rnd_b = (sum + SUMW'(1 << 13)) >>> 14;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ac_s1   <= a * c;
			bs_s1   <= b * s;
			as_s1   <= a * s;
			bc_s1   <= b * c;
			side_s1 <= side_in;
			na_s2   <= RW'(rnd_a);
			nb_s2   <= RW'(rnd_b);
			side_s2 <= side_s1;
		end
	end

	assign out_valid = valid_s2;
	assign na        = na_s2;
	assign nb        = nb_s2;
	assign side_out  = side_s2;

endmodule

// ----- src/vrp_div_cell.sv -----
// vrp_div_cell: one restoring-division quotient bit for both screen axes
// depends on vrp_pkg
`timescale 1ns / 1ps
module vrp_div_cell
	import vrp_pkg::*;
#(
	parameter int BIT = 0,
	parameter int RMW = 54,
	parameter int QW  = 27,
	parameter int SW  = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [RMW-1:0]      den_in,
	input  logic [1:0][RMW-1:0] rem_in,
	input  logic [1:0][QW-1:0]  quo_in,
	input  logic [SW-1:0]       side_in,
	output logic                out_valid,
	output logic [RMW-1:0]      den_out,
	output logic [1:0][RMW-1:0] rem_out,
	output logic [1:0][QW-1:0]  quo_out,
	output logic [SW-1:0]       side_out
);

	logic [RMW-1:0]      den_sh;
	logic [1:0][RMW-1:0] rem_d, rem_q;
	logic [1:0][QW-1:0]  quo_d, quo_q;
	logic [RMW-1:0]      den_q;
	logic [SW-1:0]       side_q;
	logic                valid_q;

	assign den_sh = den_in << BIT;

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			rem_d[k] = rem_in[k];
			quo_d[k] = quo_in[k];
			if (rem_in[k] >= den_sh) begin
				rem_d[k]      = rem_in[k] - den_sh;
				quo_d[k][BIT] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= rem_d;
			quo_q  <= quo_d;
			den_q  <= den_in;
			side_q <= side_in;
		end
	end

	assign out_valid = valid_q;
	assign den_out   = den_q;
	assign rem_out   = rem_q;
	assign quo_out   = quo_q;
	assign side_out  = side_q;

endmodule

// ----- src/vertex_rotate_project.sv -----
// vertex_rotate_project: euler x-y-z rotation of a q8.8 vertex and perspective projection
// depends on vrp_pkg, vrp_cordic_cell, vrp_rot, vrp_div_cell
// stages: angle fold, cordic, trig rounding, rotation, projection, divider, output
// throughput: one vertex per cycle; every stage holds while a result waits at the output
// reset: valid flags clear and all configuration registers return to 0
`timescale 1ns / 1ps
module vertex_rotate_project
	import vrp_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] vertex_x,
	input  logic signed [COORD_BITS-1:0] vertex_y,
	input  logic signed [COORD_BITS-1:0] vertex_z,
	input  logic [ANGLE_BITS-1:0]        angle_x,
	input  logic [ANGLE_BITS-1:0]        angle_y,
	input  logic [ANGLE_BITS-1:0]        angle_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [PIXEL_W-1:0]    screen_x,
	output logic signed [PIXEL_W-1:0]    screen_y,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]             cfg_data
);

	localparam int RW   = COORD_BITS + 2;
	localparam int DW   = ((RW > VDIST_W + 1) ? RW : VDIST_W + 1) + 1;
	localparam int DNW  = DW + 8;
	localparam int CPW  = CENTER_W + DW;
	localparam int FPW  = RW + FOCAL_W + 1;
	localparam int NW   = ((CPW + 9 > FPW) ? CPW + 9 : FPW) + 1;
	localparam int QB   = NW - 12;
	localparam int RMW  = (NW > DNW + QB) ? NW : DNW + QB;
	localparam int CSW  = 3 * COORD_BITS;
	localparam int XSW  = RW + 4 * TRIG_W;
	localparam int YSW  = RW + 2 * TRIG_W;

	logic                  en;
	logic [CENTER_W-1:0]   cx_q, cy_q;
	logic [FOCAL_W-1:0]    focal_q;
	logic [VDIST_W-1:0]    vdist_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q    <= '0;
			cy_q    <= '0;
			focal_q <= '0;
			vdist_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_CENTER_X: cx_q    <= cfg_data[CENTER_W-1:0];
				REG_CENTER_Y: cy_q    <= cfg_data[CENTER_W-1:0];
				REG_FOCAL:    focal_q <= cfg_data[FOCAL_W-1:0];
				REG_VDIST:    vdist_q <= cfg_data[VDIST_W-1:0];
				default:      ;
			endcase
		end
	end

	function automatic cord_t fold_angle(input logic [ANGLE_BITS-1:0] a);
		logic [31:0]          t;
		logic signed [CW-1:0] z;
		cord_t                l;
		t      = {a, {(32 - ANGLE_BITS){1'b0}}};
		z      = CW'($signed(t));
		l.x    = CORDIC_GAIN;
		l.y    = '0;
		l.z    = z;
		l.flip = 1'b0;
		if (z > TURN_QUARTER) begin
			l.z    = z - TURN_HALF;
			l.flip = 1'b1;
		end else if (z < -TURN_QUARTER) begin
			l.z    = z + TURN_HALF;
			l.flip = 1'b1;
		end
		return l;
	endfunction

	function automatic logic signed [TRIG_W-1:0] round_trig(input logic signed [CW-1:0] v,
		input logic flip);
		logic signed [CW-1:0] t;
		logic signed [CW-1:0] r;
		t = flip ? -v : v;
		r = (t + CW'(1 << 15)) >>> 16;
		if (r > CW'(16384))
			return TRIG_W'(16384);
		if (r < CW'(-16384))
			return TRIG_W'(-16384);
		return TRIG_W'(r);
	endfunction

	function automatic logic signed [PIXEL_W-1:0] saturate(input logic [QB-1:0] q,
		input logic neg);
		if (!neg) begin
			if (q > QB'(32767))
				return PIXEL_W'(32767);
			return PIXEL_W'(q);
		end
		if (q > QB'(32768))
			return PIXEL_W'(-32768);
		return PIXEL_W'(~q + 1'b1);
	endfunction

	// angle folding
	cord_t [2:0]      lane_s0;
	logic [CSW-1:0]   vert_s0;
	logic             valid_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (en) begin
			valid_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s0[0] <= fold_angle(angle_x);
			lane_s0[1] <= fold_angle(angle_y);
			lane_s0[2] <= fold_angle(angle_z);
			vert_s0    <= {vertex_z, vertex_y, vertex_x};
		end
	end

	// cordic cell chain
	cord_t [2:0]    lane_c  [0:STEPS];
	logic [CSW-1:0] vert_c  [0:STEPS];
	logic           valid_c [0:STEPS];

	assign lane_c[0]  = lane_s0;
	assign vert_c[0]  = vert_s0;
	assign valid_c[0] = valid_s0;

	for (genvar i = 0; i < STEPS; i++) begin : g_cordic
		vrp_cordic_cell #(
			.STEP(i),
			.SW  (CSW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (valid_c[i]),
			.lane_in  (lane_c[i]),
			.side_in  (vert_c[i]),
			.out_valid(valid_c[i+1]),
			.lane_out (lane_c[i+1]),
			.side_out (vert_c[i+1])
		);
	end

	// trig rounding
	logic signed [TRIG_W-1:0] c0_s17, s0_s17, c1_s17, s1_s17, c2_s17, s2_s17;
	logic signed [RW-1:0]     vx_s17, vy_s17, vz_s17;
	logic                     valid_s17;
	cord_t [2:0]              lane_e;
	logic [CSW-1:0]           vert_e;

	assign lane_e = lane_c[STEPS];
	assign vert_e = vert_c[STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s17 <= 1'b0;
		end else if (en) begin
			valid_s17 <= valid_c[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c0_s17 <= round_trig(lane_e[0].x, lane_e[0].flip);
			s0_s17 <= round_trig(lane_e[0].y, lane_e[0].flip);
			c1_s17 <= round_trig(lane_e[1].x, lane_e[1].flip);
			s1_s17 <= round_trig(lane_e[1].y, lane_e[1].flip);
			c2_s17 <= round_trig(lane_e[2].x, lane_e[2].flip);
			s2_s17 <= round_trig(lane_e[2].y, lane_e[2].flip);
			vx_s17 <= RW'($signed(vert_e[COORD_BITS-1:0]));
			vy_s17 <= RW'($signed(vert_e[2*COORD_BITS-1:COORD_BITS]));
			vz_s17 <= RW'($signed(vert_e[3*COORD_BITS-1:2*COORD_BITS]));
		end
	end

	// rotation about x, y, z
	logic                     valid_rx, valid_ry, valid_rz;
	logic signed [RW-1:0]     y1, z1, z2, x2, x3, y3;
	logic [XSW-1:0]           side_rx;
	logic [YSW-1:0]           side_ry;
	logic [RW-1:0]            side_rz;
	logic signed [RW-1:0]     vx_rx, y1_ry, z2_rz;
	logic signed [TRIG_W-1:0] c1_rx, s1_rx, c2_rx, s2_rx, c2_ry, s2_ry;

	vrp_rot #(.RW(RW), .SW(XSW)) u_rot_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s17),
		.a        (vy_s17),
		.b        (vz_s17),
		.c        (c0_s17),
		.s        (s0_s17),
		.side_in  ({vx_s17, c1_s17, s1_s17, c2_s17, s2_s17}),
		.out_valid(valid_rx),
		.na       (y1),
		.nb       (z1),
		.side_out (side_rx)
	);

	assign {vx_rx, c1_rx, s1_rx, c2_rx, s2_rx} = side_rx;

	vrp_rot #(.RW(RW), .SW(YSW)) u_rot_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_rx),
		.a        (z1),
		.b        (vx_rx),
		.c        (c1_rx),
		.s        (s1_rx),
		.side_in  ({y1, c2_rx, s2_rx}),
		.out_valid(valid_ry),
		.na       (z2),
		.nb       (x2),
		.side_out (side_ry)
	);

	assign {y1_ry, c2_ry, s2_ry} = side_ry;

	vrp_rot #(.RW(RW), .SW(RW)) u_rot_z (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_ry),
		.a        (x2),
		.b        (y1_ry),
		.c        (c2_ry),
		.s        (s2_ry),
		.side_in  (z2),
		.out_valid(valid_rz),
		.na       (x3),
		.nb       (y3),
		.side_out (side_rz)
	);

	assign z2_rz = side_rz;

	// projection set-up
	logic signed [DW-1:0]  dsum;
	logic [DW-1:0]         d_p1;
	logic signed [RW-1:0]  x_p1, y_p1;
	logic [CPW-1:0]        cxd_p2, cyd_p2;
	logic signed [FPW-1:0] xf_p2, yf_p2;
	logic [DNW-1:0]        den_p2, den_p3;
	logic signed [NW-1:0]  nx_p3, ny_p3;
	logic [RMW-1:0]        den_p4, rx_p4, ry_p4;
	logic                  negx_p4, negy_p4;
	logic [NW-1:0]         absx, absy;
	logic                  valid_p1, valid_p2, valid_p3, valid_p4;

	always_comb begin
		dsum = DW'(z2_rz) + $signed({{(DW - VDIST_W){1'b0}}, vdist_q});
		absx = nx_p3[NW-1] ? NW'(-nx_p3) : NW'(nx_p3);
		absy = ny_p3[NW-1] ? NW'(-ny_p3) : NW'(ny_p3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_p1 <= 1'b0;
			valid_p2 <= 1'b0;
			valid_p3 <= 1'b0;
			valid_p4 <= 1'b0;
		end else if (en) begin
			valid_p1 <= valid_rz;
			valid_p2 <= valid_p1;
			valid_p3 <= valid_p2;
			valid_p4 <= valid_p3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_p1    <= (dsum < DW'(MIN_DEPTH)) ? DW'(MIN_DEPTH) : DW'(dsum);
			x_p1    <= x3;
			y_p1    <= y3;
			cxd_p2  <= CPW'(cx_q) * CPW'(d_p1);
			cyd_p2  <= CPW'(cy_q) * CPW'(d_p1);
			xf_p2   <= x_p1 * $signed({1'b0, focal_q});
			yf_p2   <= y_p1 * $signed({1'b0, focal_q});
			den_p2  <= {d_p1, 8'd0};
			nx_p3   <= $signed(NW'({cxd_p2, 8'd0})) + NW'(xf_p2);
			ny_p3   <= $signed(NW'({cyd_p2, 8'd0})) + NW'(yf_p2);
			den_p3  <= den_p2;
			rx_p4   <= RMW'(absx);
			ry_p4   <= RMW'(absy);
			negx_p4 <= nx_p3[NW-1];
			negy_p4 <= ny_p3[NW-1];
			den_p4  <= RMW'(den_p3);
		end
	end

	// divider cell chain
	logic [RMW-1:0]      den_c  [0:QB];
	logic [1:0][RMW-1:0] rem_c  [0:QB];
	logic [1:0][QB-1:0]  quo_c  [0:QB];
	logic [1:0]          sgn_c  [0:QB];
	logic                dval_c [0:QB];

	assign den_c[0]  = den_p4;
	assign rem_c[0]  = {ry_p4, rx_p4};
	assign quo_c[0]  = '0;
	assign sgn_c[0]  = {negy_p4, negx_p4};
	assign dval_c[0] = valid_p4;

	for (genvar i = 0; i < QB; i++) begin : g_div
		vrp_div_cell #(
			.BIT(QB - 1 - i),
			.RMW(RMW),
			.QW (QB),
			.SW (2)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (dval_c[i]),
			.den_in   (den_c[i]),
			.rem_in   (rem_c[i]),
			.quo_in   (quo_c[i]),
			.side_in  (sgn_c[i]),
			.out_valid(dval_c[i+1]),
			.den_out  (den_c[i+1]),
			.rem_out  (rem_c[i+1]),
			.quo_out  (quo_c[i+1]),
			.side_out (sgn_c[i+1])
		);
	end

	// output register
	logic                      out_valid_q;
	logic signed [PIXEL_W-1:0] screen_x_q, screen_y_q;
	logic [1:0][QB-1:0]        quo_e;
	logic [1:0]                sgn_e;

	assign quo_e = quo_c[QB];
	assign sgn_e = sgn_c[QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dval_c[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			screen_x_q <= saturate(quo_e[0], sgn_e[0]);
			screen_y_q <= saturate(quo_e[1], sgn_e[1]);
		end
	end

	assign en        = !out_valid_q || out_ready;
	assign in_ready  = en;
	assign out_valid = out_valid_q;
	assign screen_x  = screen_x_q;
	assign screen_y  = screen_y_q;

endmodule

// ----- src/vrp_checker.sv -----
// vrp_checker: port-level checks on the vertex rotate/project block
// depends on vrp_pkg; bound to vertex_rotate_project
`timescale 1ns / 1ps
module vrp_checker
	import vrp_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic signed [COORD_BITS-1:0] vertex_x,
	input logic signed [COORD_BITS-1:0] vertex_y,
	input logic signed [COORD_BITS-1:0] vertex_z,
	input logic [ANGLE_BITS-1:0]        angle_x,
	input logic [ANGLE_BITS-1:0]        angle_y,
	input logic [ANGLE_BITS-1:0]        angle_z,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic signed [PIXEL_W-1:0]    screen_x,
	input logic signed [PIXEL_W-1:0]    screen_y,
	input logic                         cfg_we,
	input logic [CFG_IDX_W-1:0]         cfg_index,
	input logic [CFG_W-1:0]             cfg_data
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(screen_x) && $stable(screen_y))
		else $error("result changed while stalled");

	// an empty output stage never blocks a request
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// downstream ready lets the pipeline advance
	a_ready_pass: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output ready");

endmodule

bind vertex_rotate_project vrp_checker #(
	.COORD_BITS(COORD_BITS),
	.ANGLE_BITS(ANGLE_BITS)
) u_vrp_checker (.*);
